/* design/rasum_pkg.sv */
// Shared types and constants for the range-add / range-sum table.
// No dependencies; used by the top level, its port list, the checker and the testbench.
package rasum_pkg;

    // Default number of table positions
    localparam int unsigned C_DEPTH = 1024;

    // Field widths
    localparam int unsigned C_IDX_W = 11;
    localparam int unsigned C_VAL_W = 32;
    localparam int unsigned C_SUM_W = 64;

    // Length register value after reset
    localparam logic [C_IDX_W-1:0] C_LEN_RESET = 11'd1024;

    // Command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [C_SUM_W-1:0] t_sum;

endpackage

/* design/rasum_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; instanced once per tree by the top level.
module rasum_ram #(
    parameter int unsigned WIDTH  = 64,
    parameter int unsigned DEPTH  = 1025,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data (old data on a same-address access)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/range_add_range_sum_table.sv */
// Range-add / range-sum table held in two Fenwick trees (D and i*D[i]) in RAM.
// Reset: synchronous, active low; then a clearing pass writes zero to all DEPTH+1
// entries of both trees, with input stalled (config still taken).
// Add: an update walk from left (and one from right+1 if right+1 <= DEPTH), each
// over up to log2(DEPTH)+1 tree entries, one read-modify-write per cycle.
// Query: prefix walks for right, then left-1, each with its multiply steps; invalid: flagged emit.
module range_add_range_sum_table #(
    parameter int unsigned DEPTH = rasum_pkg::C_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_command,
    input  logic [rasum_pkg::C_IDX_W-1:0]          i_left_index,
    input  logic [rasum_pkg::C_IDX_W-1:0]          i_right_index,
    input  logic signed [rasum_pkg::C_VAL_W-1:0]   i_add_value,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [rasum_pkg::C_SUM_W-1:0]   o_range_sum,
    output logic                                   o_range_error,
    // configuration channel (length register)
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rasum_pkg::C_IDX_W-1:0]          i_cfg_length
);

    import rasum_pkg::*;

    // RAM address width and position arithmetic width (holds 2*DEPTH and right+1)
    localparam int unsigned AW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (AW + 1 > C_IDX_W + 1) ? AW + 1 : C_IDX_W + 1;
    // Multiplier: 33-bit signed by (PW+1)-bit signed
    localparam int unsigned MA = C_VAL_W + 1;
    localparam int unsigned MB = PW + 1;
    localparam int unsigned MW = MA + MB;

    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
    localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);

    // State codes
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_UWALK = 4'd3;
    localparam logic [3:0] S_QWALK = 4'd4;
    localparam logic [3:0] S_QMLO  = 4'd5;
    localparam logic [3:0] S_QMHI  = 4'd6;
    localparam logic [3:0] S_QSUM  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    function automatic logic [PW-1:0] lowest_one(input logic [PW-1:0] a);
        return a & (~a + PW'(1));
    endfunction

    // Control registers
    logic [3:0]         r_state, n_state;
    logic [C_IDX_W-1:0] r_length;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_wb_valid, n_wb_valid;
    logic               r_pend, n_pend;
    logic               r_second, n_second;
    logic               r_out_valid, n_out_valid;

    // Payload registers
    logic [PW-1:0]        r_idx, n_idx;
    logic [PW-1:0]        r_mulb, n_mulb;
    logic [PW-1:0]        r_next_idx, n_next_idx;
    logic [PW-1:0]        r_next_mulb, n_next_mulb;
    logic [AW-1:0]        r_wb_addr, n_wb_addr;
    logic signed [MA-1:0] r_v, n_v;
    t_sum                 r_ddelta, n_ddelta;
    t_sum                 r_wdelta, n_wdelta;
    t_sum                 r_sd, n_sd;
    t_sum                 r_sw, n_sw;
    t_sum                 r_plo, n_plo;
    logic [31:0]          r_phi, n_phi;
    t_sum                 r_res, n_res;
    t_sum                 r_emit_sum, n_emit_sum;
    logic                 r_emit_err, n_emit_err;
    t_sum                 r_out_sum, n_out_sum;
    logic                 r_out_err, n_out_err;

    // RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_sum          ram_wd_d, ram_wd_w, rd_d, rd_w;

    // Shared multiplier
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [MW-1:0] mul_p;
    t_sum                 mul_p64;

    // Input decode
    logic          in_acc;
    logic [PW-1:0] left_p, right_p, len_p, len_eff;
    logic          range_bad;
    logic          out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Range check against the effective length
    assign left_p    = PW'(i_left_index);
    assign right_p   = PW'(i_right_index);
    assign len_p     = PW'(r_length);
    assign len_eff   = (len_p > DEPTH_P) ? DEPTH_P : len_p;
    assign range_bad = (left_p == '0) || (left_p > right_p) || (right_p > len_eff);

    // Select multiplier operands: point weight in update, (p+1) times a sum half in query
    always_comb begin
        mul_b = signed'({1'b0, r_mulb});
        case (r_state)
            S_QMLO:  mul_a = signed'({1'b0, r_sd[31:0]});
            S_QMHI:  mul_a = signed'({1'b0, r_sd[63:32]});
            default: mul_a = r_v;
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_p64 = {{(C_SUM_W - MW){mul_p[MW-1]}}, mul_p};

    // RAM control: clearing pass, then read-modify-write or prefix reads
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];
        if (r_state == S_UWALK) begin
            ram_re = (r_idx <= DEPTH_P);
        end else if (r_state == S_QWALK) begin
            ram_re = (r_idx != '0);
        end
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wd_d  = '0;
            ram_wd_w  = '0;
        end else begin
            ram_we    = (r_state == S_UWALK) && r_wb_valid;
            ram_waddr = r_wb_addr;
            ram_wd_d  = rd_d + r_ddelta;
            ram_wd_w  = rd_w + r_wdelta;
        end
    end

    rasum_ram #(
        .WIDTH (C_SUM_W),
        .DEPTH (DEPTH + 1),
        .ADDR_W(AW)
    ) u_diff_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wd_d),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd_d)
    );

    rasum_ram #(
        .WIDTH (C_SUM_W),
        .DEPTH (DEPTH + 1),
        .ADDR_W(AW)
    ) u_wdiff_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wd_w),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd_w)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_wb_valid  = 1'b0;
        n_wb_addr   = r_idx[AW-1:0];
        n_pend      = 1'b0;
        n_second    = r_second;
        n_idx       = r_idx;
        n_mulb      = r_mulb;
        n_next_idx  = r_next_idx;
        n_next_mulb = r_next_mulb;
        n_v         = r_v;
        n_ddelta    = r_ddelta;
        n_wdelta    = r_wdelta;
        n_sd        = r_sd;
        n_sw        = r_sw;
        n_plo       = r_plo;
        n_phi       = r_phi;
        n_res       = r_res;
        n_emit_sum  = r_emit_sum;
        n_emit_err  = r_emit_err;

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == DEPTH_A) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_second = 1'b0;
                n_v      = MA'(i_add_value);
                n_sd     = '0;
                n_sw     = '0;
                n_res    = '0;
                if (in_acc) begin
                    if (range_bad) begin
                        n_emit_sum = '0;
                        n_emit_err = 1'b1;
                        n_state    = S_EMIT;
                    end else if (i_command == CMD_ADD) begin
                        n_idx       = left_p;
                        n_mulb      = left_p;
                        n_next_idx  = right_p + PW'(1);
                        n_next_mulb = right_p + PW'(1);
                        n_state     = S_MUL;
                    end else begin
                        n_idx       = right_p;
                        n_mulb      = right_p + PW'(1);
                        n_next_idx  = left_p - PW'(1);
                        n_next_mulb = left_p;
                        n_state     = S_QWALK;
                    end
                end
            end
            S_MUL: begin
                n_ddelta = t_sum'(r_v);
                n_wdelta = mul_p64;
                n_state  = S_UWALK;
            end
            S_UWALK: begin
                // issue a read and write back the entry read last cycle
                if (r_idx <= DEPTH_P) begin
                    n_wb_valid = 1'b1;
                    n_idx      = r_idx + lowest_one(r_idx);
                end else if (!r_wb_valid) begin
                    if (!r_second && (r_next_idx <= DEPTH_P)) begin
                        n_second = 1'b1;
                        n_idx    = r_next_idx;
                        n_mulb   = r_next_mulb;
                        n_v      = -r_v;
                        n_state  = S_MUL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_QWALK: begin
                // issue prefix reads; accumulate each read's data in the following cycle
                if (r_pend) begin
                    n_sd = r_sd + rd_d;
                    n_sw = r_sw + rd_w;
                end
                if (r_idx != '0) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx - lowest_one(r_idx);
                end else if (!r_pend) begin
                    n_state = S_QMLO;
                end
            end
            S_QMLO: begin
                n_plo   = mul_p64;
                n_state = S_QMHI;
            end
            S_QMHI: begin
                n_phi   = mul_p64[31:0];
                n_plo   = r_plo - r_sw;
                n_state = S_QSUM;
            end
            S_QSUM: begin
                // fold (p+1)*sumD - sumiD into the result, second prefix subtracted
                if (r_second) begin
                    n_res      = r_res - (r_plo + {r_phi, 32'd0});
                    n_emit_sum = n_res;
                    n_emit_err = 1'b0;
                    n_state    = S_EMIT;
                end else begin
                    n_res    = r_res + (r_plo + {r_phi, 32'd0});
                    n_second = 1'b1;
                    n_idx    = r_next_idx;
                    n_mulb   = r_next_mulb;
                    n_sd     = '0;
                    n_sw     = '0;
                    n_state  = S_QWALK;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load on emit, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_err   = r_out_err;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_EMIT) && out_free) begin
            n_out_valid = 1'b1;
            n_out_sum   = r_emit_sum;
            n_out_err   = r_emit_err;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_length    <= C_LEN_RESET;
            r_clr       <= '0;
            r_wb_valid  <= 1'b0;
            r_pend      <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_wb_valid  <= n_wb_valid;
            r_pend      <= n_pend;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_length <= i_cfg_length;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_mulb      <= n_mulb;
        r_next_idx  <= n_next_idx;
        r_next_mulb <= n_next_mulb;
        r_wb_addr   <= n_wb_addr;
        r_v         <= n_v;
        r_ddelta    <= n_ddelta;
        r_wdelta    <= n_wdelta;
        r_sd        <= n_sd;
        r_sw        <= n_sw;
        r_plo       <= n_plo;
        r_phi       <= n_phi;
        r_res       <= n_res;
        r_emit_sum  <= n_emit_sum;
        r_emit_err  <= n_emit_err;
        r_out_sum   <= n_out_sum;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid   = r_out_valid;
    assign o_range_sum   = signed'(r_out_sum);
    assign o_range_error = r_out_err;

`ifndef SYNTHESIS
    // Write-back never hits the entry being read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UWALK && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("update walk reads the entry it is writing back");

    // Prefix walk stays inside the table
    a_qwalk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWALK) |-> (r_idx <= DEPTH_P))
        else $error("prefix walk index beyond table depth");

    // Flagged results carry a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_range_sum == '0))
        else $error("error transaction with nonzero sum");

    // A result is loaded only from the emit state
    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == S_EMIT))
        else $error("result loaded outside emit state");
`endif

endmodule

/* verif/range_sum_checker.sv */
// Checker for the range-add / range-sum table: watches all three channels,
// keeps its own pair of Fenwick trees and compares every result transaction.
// Depends on rasum_pkg for widths, command codes and the length reset value.
module range_sum_checker #(
    parameter int unsigned DEPTH = rasum_pkg::C_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item channel
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic                                 i_command,
    input  logic [rasum_pkg::C_IDX_W-1:0]        i_left_index,
    input  logic [rasum_pkg::C_IDX_W-1:0]        i_right_index,
    input  logic [rasum_pkg::C_VAL_W-1:0]        i_add_value,
    // result channel
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic [rasum_pkg::C_SUM_W-1:0]        i_range_sum,
    input  logic                                 i_range_error,
    // configuration channel
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [rasum_pkg::C_IDX_W-1:0]        i_cfg_length,
    // status for the testbench top
    output int                                   o_failures,
    output int                                   o_pending,
    output int                                   o_items,
    output int                                   o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import rasum_pkg::*;

    typedef struct packed {
        t_sum sum;
        logic flag;
    } t_sum_result;

    // Shadow copy of both trees and the length register
    t_sum                diff_tree  [0:DEPTH];
    t_sum                wdiff_tree [0:DEPTH];
    logic [C_IDX_W-1:0]  length_reg = C_LEN_RESET;
    t_sum_result         expected_sums [$];

    int fail_total   = 0;
    int item_total   = 0;
    int result_total = 0;

    // Add v at one point of the difference array, walking up to DEPTH
    function automatic void tree_point_add(int unsigned pos, t_sum v);
        t_sum        weighted;
        int unsigned i;
        weighted = t_sum'(pos) * v;
        i = pos;
        while (i <= DEPTH) begin
            diff_tree[i]  += v;
            wdiff_tree[i] += weighted;
            i += i & (~i + 1);
        end
    endfunction

    // Prefix total (pos+1)*sumD(pos) - sum_iD(pos)
    function automatic t_sum tree_prefix(int unsigned pos);
        t_sum        sd;
        t_sum        sw;
        int unsigned i;
        sd = '0;
        sw = '0;
        i  = (pos > DEPTH) ? DEPTH : pos;
        while (i > 0) begin
            sd += diff_tree[i];
            sw += wdiff_tree[i];
            i -= i & (~i + 1);
        end
        return (t_sum'(pos) + 1) * sd - sw;
    endfunction

    // Apply one accepted item and queue the result it causes, if any
    function automatic void predict_item(logic cmd, logic [C_IDX_W-1:0] left_idx,
                                         logic [C_IDX_W-1:0] right_idx,
                                         logic [C_VAL_W-1:0] amount);
        int unsigned n;
        int unsigned l;
        int unsigned r;
        t_sum        v;
        t_sum_result res;
        n = (int'(length_reg) > DEPTH) ? DEPTH : int'(length_reg);
        l = 32'(left_idx);
        r = 32'(right_idx);
        if (l == 0 || l > r || r > n) begin
            res.sum  = '0;
            res.flag = 1'b1;
            expected_sums.push_back(res);
        end else if (cmd == CMD_ADD) begin
            v = {{(C_SUM_W-C_VAL_W){amount[C_VAL_W-1]}}, amount};
            tree_point_add(l, v);
            if (r + 1 <= DEPTH)
                tree_point_add(r + 1, t_sum'(0) - v);
        end else begin
            res.sum  = tree_prefix(r) - tree_prefix(l - 1);
            res.flag = 1'b0;
            expected_sums.push_back(res);
        end
    endfunction

    // Sample all channels at the clock edge
    always @(posedge i_clk) begin : monitor
        t_sum_result head;
        if (!i_rst_n) begin
            for (int k = 0; k <= DEPTH; k++) begin
                diff_tree[k]  = '0;
                wdiff_tree[k] = '0;
            end
            length_reg = C_LEN_RESET;
            expected_sums.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                length_reg = i_cfg_length;

            // Compare a result transaction against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                result_total++;
                if (expected_sums.size() == 0) begin
                    $error("unexpected result: range_sum %0d, range_error %0b",
                           $signed(i_range_sum), i_range_error);
                    fail_total++;
                end else begin
                    head = expected_sums.pop_front();
                    if (head.sum !== i_range_sum) begin
                        $error("range_sum mismatch: expected %0d, actual %0d",
                               $signed(head.sum), $signed(i_range_sum));
                        fail_total++;
                    end
                    if (head.flag !== i_range_error) begin
                        $error("range_error mismatch: expected %0b, actual %0b",
                               head.flag, i_range_error);
                        fail_total++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                item_total++;
                predict_item(i_command, i_left_index, i_right_index, i_add_value);
            end
        end
        o_failures <= fail_total;
        o_pending  <= expected_sums.size();
        o_items    <= item_total;
        o_results  <= result_total;
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the range-add / range-sum table: drives items, results
// back-pressure and length writes; range_sum_checker predicts and compares.
// Depends on rasum_pkg, range_add_range_sum_table and range_sum_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rasum_pkg::*;

    localparam int unsigned DEPTH          = C_DEPTH;
    localparam int          DRAIN_CYCLES   = 48;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_CYCLES    = 400;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                i_command     = CMD_ADD;
    logic [C_IDX_W-1:0]  i_left_index  = '0;
    logic [C_IDX_W-1:0]  i_right_index = '0;
    logic [C_VAL_W-1:0]  i_add_value   = '0;
    logic                i_out_stall   = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [C_IDX_W-1:0]  i_cfg_length  = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [C_SUM_W-1:0]  o_range_sum;
    logic                o_range_error;
    logic                o_cfg_ready;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cur_len       = C_LEN_RESET;
    int          lengths_set   = 0;
    bit          hold_req      = 1'b0;
    bit          hold_taken    = 1'b0;
    int          hold_left     = 0;
    int          idle_cycles   = 0;

    range_add_range_sum_table #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_left_index  (i_left_index),
        .i_right_index (i_right_index),
        .i_add_value   (i_add_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_range_sum   (o_range_sum),
        .o_range_error (o_range_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_length  (i_cfg_length)
    );

    range_sum_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_left_index  (i_left_index),
        .i_right_index (i_right_index),
        .i_add_value   (i_add_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_range_sum   (o_range_sum),
        .i_range_error (o_range_error),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_length  (i_cfg_length),
        .o_failures    (fail_count),
        .o_pending     (pending),
        .o_items       (items_seen),
        .o_results     (results_seen)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result back-pressure: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_taken  <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // End the run when no transaction moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles, %0d results pending",
                   idle_cycles, pending);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item after optional idle cycles; hold it until accepted
    task automatic send_item(input logic cmd, input int unsigned l, input int unsigned r,
                             input logic [C_VAL_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_left_index  <= l[C_IDX_W-1:0];
        i_right_index <= r[C_IDX_W-1:0];
        i_add_value   <= v;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid, let the last item reach the pending count, wait for every
    // pending result, then let adds finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input int unsigned len);
        settle();
        i_cfg_valid  <= 1'b1;
        i_cfg_length <= len[C_IDX_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_len = len;
        lengths_set++;
    endtask

    function automatic logic [C_VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 15));
            3:       return 32'(0) - 32'($urandom_range(1, 15));
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed ranges inside the length, the rest broken or random ranges
    task automatic random_item();
        int unsigned n;
        int unsigned l;
        int unsigned r;
        int unsigned span;
        logic        cmd;
        n   = (cur_len > DEPTH) ? DEPTH : cur_len;
        cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_ADD;
        if (n != 0 && $urandom_range(0, 99) < 85) begin
            l = $urandom_range(1, n);
            if ($urandom_range(0, 1)) begin
                span = $urandom_range(0, 7);
                r    = (l + span > n) ? n : l + span;
            end else begin
                r = $urandom_range(l, n);
            end
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    l = 0;
                    r = $urandom_range(0, 2047);
                end
                1: begin
                    r = $urandom_range(1, 1023);
                    l = $urandom_range(r + 1, 2047);
                end
                2: begin
                    r = $urandom_range(n + 1, 2047);
                    l = $urandom_range(1, r);
                end
                default: begin
                    l = $urandom_range(0, 2047);
                    r = $urandom_range(0, 2047);
                end
            endcase
        end
        send_item(cmd, l, r, pick_value());
    endtask

    task automatic random_phase(input int count);
        write_length($urandom_range(0, 3) == 0 ? DEPTH : $urandom_range(2, DEPTH));
        repeat (count) random_item();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of the fields at the reset length
        send_item(CMD_QUERY, 1, 1024, '0);
        send_item(CMD_ADD, 1, 1024, 32'h7FFF_FFFF);
        send_item(CMD_ADD, 1, 1, 32'h8000_0000);
        send_item(CMD_ADD, 1024, 1024, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 512, 513, 32'h5555_5555);
        send_item(CMD_QUERY, 1, 1, '0);
        send_item(CMD_QUERY, 1024, 1024, '0);
        send_item(CMD_QUERY, 1, 1024, '0);
        send_item(CMD_QUERY, 2, 1023, '0);
        send_item(CMD_QUERY, 513, 513, '0);
        // Directed: broken ranges for both commands, then a full-range query
        send_item(CMD_QUERY, 0, 5, '0);
        send_item(CMD_ADD, 0, 0, 32'h1234_5678);
        send_item(CMD_ADD, 5, 4, 32'h0000_0007);
        send_item(CMD_QUERY, 1, 1025, '0);
        send_item(CMD_ADD, 2047, 2047, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 3, 2047, '0);
        send_item(CMD_QUERY, 1, 1024, '0);

        // Directed: length of one, of zero, and beyond the table
        write_length(1);
        send_item(CMD_ADD, 1, 1, 32'h0000_0003);
        send_item(CMD_QUERY, 1, 1, '0);
        send_item(CMD_QUERY, 1, 2, '0);
        write_length(0);
        send_item(CMD_QUERY, 1, 1, '0);
        send_item(CMD_ADD, 1, 1, 32'h0000_0001);
        write_length(2047);
        send_item(CMD_QUERY, 1, 1024, '0);
        send_item(CMD_QUERY, 1, 1025, '0);

        // Sender idles lightly, receiver heavily
        send_idle_pct = 18;
        recv_idle_pct = 87;
        repeat (3) random_phase(160);

        // Sender idles heavily, receiver lightly
        send_idle_pct = 87;
        recv_idle_pct = 18;
        repeat (3) random_phase(160);

        // No idling; first hold the receiver off while queries pile up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_length(DEPTH);
        hold_req = 1'b1;
        repeat (80) begin
            send_item(CMD_QUERY, $urandom_range(1, 16), $urandom_range(16, DEPTH), '0);
        end
        // Pause the sender until every result is back
        settle();
        repeat (3) random_phase(130);

        settle();
        $display("Run covered %0d item transactions and %0d result transactions",
                 items_seen, results_seen);
        $display("over %0d length settings, broken ranges and a long result hold-off",
                 lengths_set);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rasum_pkg.sv
design/rasum_ram.sv
design/range_add_range_sum_table.sv
verif/range_sum_checker.sv
verif/tb_top.sv
